>>> hw/rtl/hfoc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// HVAC fan overrun controller package
// Shared item types, configuration codes and reset values.
// ---------------------------------------------------------------------------
package hfoc_pkg;

   localparam int SecW   = 16;
   localparam int DtW    = 8;
   localparam int SpeedW = 3;
   localparam int ModeW  = 2;
   localparam int CsrIdxW = 3;

   localparam logic [CsrIdxW-1:0] CSR_FAN_ON_DELAY   = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_FAN_OFF_DELAY  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_BLOWER_OVERRUN = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_HEAT_FAN_SPEED = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_IDLE_FAN_SPEED = 3'd4;

   localparam logic [SecW-1:0]   RST_FAN_ON_DELAY   = 16'd60;
   localparam logic [SecW-1:0]   RST_FAN_OFF_DELAY  = 16'd180;
   localparam logic [SecW-1:0]   RST_BLOWER_OVERRUN = 16'd360;
   localparam logic [SpeedW-1:0] RST_HEAT_FAN_SPEED = 3'd2;
   localparam logic [SpeedW-1:0] RST_IDLE_FAN_SPEED = 3'd1;
   localparam logic [SecW-1:0]   RST_SINCE_CHANGE   = 16'd360;
   localparam logic [SecW-1:0]   SEC_MAX            = 16'hFFFF;

   localparam logic [ModeW-1:0]  MODE_ON = 2'd2;

   typedef struct packed {
      logic [SecW-1:0]   fan_on_delay;
      logic [SecW-1:0]   fan_off_delay;
      logic [SecW-1:0]   blower_overrun;
      logic [SpeedW-1:0] heat_fan_speed;
      logic [SpeedW-1:0] idle_fan_speed;
   } cfg_type;

   typedef struct packed {
      logic             fan_write_ok;
      logic [DtW-1:0]   elapsed_seconds;
      logic [ModeW-1:0] blower_mode;
      logic             heat_active;
      logic             reading_ok;
   } req_item_type;

   typedef struct packed {
      logic [ModeW-1:0]  blower_cmd;
      logic              blower_cmd_valid;
      logic [SpeedW-1:0] fan_speed;
      logic              fan_cmd_valid;
   } rsp_item_type;

endpackage
`default_nettype wire

>>> hw/rtl/hfoc_csr.sv
`default_nettype none
// ---------------------------------------------------------------------------
// HVAC fan overrun controller configuration registers
// Holds the delays and fan speeds written through the register port.
// ---------------------------------------------------------------------------
module hfoc_csr
   import hfoc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire logic [CsrIdxW-1:0] wr_index,
   input  wire logic [SecW-1:0]    wr_data,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_FAN_ON_DELAY:   cfg_in.fan_on_delay   = wr_data;
            CSR_FAN_OFF_DELAY:  cfg_in.fan_off_delay  = wr_data;
            CSR_BLOWER_OVERRUN: cfg_in.blower_overrun = wr_data;
            CSR_HEAT_FAN_SPEED: cfg_in.heat_fan_speed = wr_data[SpeedW-1:0];
            CSR_IDLE_FAN_SPEED: cfg_in.idle_fan_speed = wr_data[SpeedW-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fan_on_delay   <= RST_FAN_ON_DELAY;
         cfg_ff.fan_off_delay  <= RST_FAN_OFF_DELAY;
         cfg_ff.blower_overrun <= RST_BLOWER_OVERRUN;
         cfg_ff.heat_fan_speed <= RST_HEAT_FAN_SPEED;
         cfg_ff.idle_fan_speed <= RST_IDLE_FAN_SPEED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> hw/rtl/hfoc_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// HVAC fan overrun controller decision core
// Poll state and the single-pass logic that turns one poll into commands.
// ---------------------------------------------------------------------------
module hfoc_core
   import hfoc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   step,
   input  wire req_item_type item,
   input  wire cfg_type     cfg,
   output rsp_item_type result
);

   logic             seen_ff, seen_in;
   logic             prev_heat_ff, prev_heat_in;
   logic [SecW-1:0]  since_ff, since_in;
   logic             fan_done_ff, fan_done_in;
   logic             latch_valid_ff, latch_valid_in;
   logic [ModeW-1:0] latched_mode_ff, latched_mode_in;

   logic [SecW:0]    sum;
   logic [SecW-1:0]  since_adv;
   logic             heat_edge;
   logic [SecW-1:0]  fan_delay;

   always_comb begin
      sum       = {1'b0, since_ff} + {{(SecW+1-DtW){1'b0}}, item.elapsed_seconds};
      since_adv = sum[SecW] ? SEC_MAX : sum[SecW-1:0];
      heat_edge = seen_ff && (item.heat_active != prev_heat_ff);
      fan_delay = item.heat_active ? cfg.fan_on_delay : cfg.fan_off_delay;

      seen_in         = seen_ff;
      prev_heat_in    = prev_heat_ff;
      since_in        = since_adv;
      fan_done_in     = fan_done_ff;
      latch_valid_in  = latch_valid_ff;
      latched_mode_in = latched_mode_ff;
      result          = '0;

      if (item.reading_ok) begin
         seen_in      = 1'b1;
         prev_heat_in = item.heat_active;
         if (heat_edge) begin
            since_in    = '0;
            fan_done_in = 1'b0;
         end else if (!fan_done_ff && (since_adv > fan_delay)) begin
            result.fan_cmd_valid = 1'b1;
            result.fan_speed     = item.heat_active ? cfg.heat_fan_speed
                                                    : cfg.idle_fan_speed;
            fan_done_in          = item.fan_write_ok;
         end

         if (!item.heat_active && (heat_edge || (since_adv < cfg.blower_overrun))) begin
            if (!latch_valid_ff) begin
               latch_valid_in  = 1'b1;
               latched_mode_in = item.blower_mode;
            end
            if (item.blower_mode != MODE_ON) begin
               result.blower_cmd_valid = 1'b1;
               result.blower_cmd       = MODE_ON;
            end
         end else if (latch_valid_ff) begin
            if (latched_mode_ff == item.blower_mode) begin
               latch_valid_in = 1'b0;
            end else begin
               result.blower_cmd_valid = 1'b1;
               result.blower_cmd       = latched_mode_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff         <= 1'b0;
         prev_heat_ff    <= 1'b0;
         since_ff        <= RST_SINCE_CHANGE;
         fan_done_ff     <= 1'b0;
         latch_valid_ff  <= 1'b0;
         latched_mode_ff <= '0;
      end else if (step) begin
         seen_ff         <= seen_in;
         prev_heat_ff    <= prev_heat_in;
         since_ff        <= since_in;
         fan_done_ff     <= fan_done_in;
         latch_valid_ff  <= latch_valid_in;
         latched_mode_ff <= latched_mode_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/hvac_fan_overrun_controller_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// HVAC fan overrun controller
// Turns thermostat polls into ceiling fan and blower commands.
// ---------------------------------------------------------------------------
//  Port group  Direction  Width  Carries
//  req_        in         16     one thermostat poll item
//  rsp_        out        8      one command item per poll
//  csr_        in         3+16   register index and write data
//
// A poll item accepted into the input register passes through the decision logic
// into the result register when the result register is free or being taken, and
// the poll state registers update at that same edge. A new item is accepted every
// cycle while the result is not stalled. Reset clears both pipeline valid flags and
// restores all register defaults. A stalled result holds the decision stage, which
// stalls the input side.
// ---------------------------------------------------------------------------
module hvac_fan_overrun_controller_unit
   import hfoc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   // reading_ok, heat_active, blower_mode[1:0], elapsed_seconds[7:0],
   // fan_write_ok, zero fill.
   input  wire logic [15:0]        req_tdata,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   // fan_cmd_valid, fan_speed[2:0], blower_cmd_valid, blower_cmd[1:0], zero fill.
   output logic [7:0]              rsp_tdata,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [SecW-1:0]    csr_data
);

   cfg_type      cfg;
   req_item_type item_ff, item_in;
   rsp_item_type result;
   rsp_item_type rsp_ff;
   logic         item_valid_ff;
   logic         rsp_valid_ff;
   logic         advance;

   assign csr_ready  = 1'b1;
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign item_in    = req_item_type'(req_tdata[$bits(req_item_type)-1:0]);

   hfoc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   hfoc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_tready) begin
            item_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> item_valid_ff)
      else $error("input side stalled with an empty input register");

   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("a decided item did not reach the result register");

   assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input accepted while the pipeline is blocked");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[3:1] == '0))
      else $error("fan speed given without a fan command");

endmodule
`default_nettype wire

>>> sim/hvac_fan_overrun_controller_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HVAC fan overrun controller testbench
// Drives thermostat poll items with random gaps and result stalls, predicts
// the fan and blower commands of every accepted poll and checks each result
// item field by field, in order, against the predicted commands.
// ---------------------------------------------------------------------------
module hvac_fan_overrun_controller_unit_tb
   import hfoc_pkg::*;
();

   localparam int CYCLE_LIMIT = 300000;
   localparam logic [ModeW-1:0] MODE_AUTO = 2'd0;
   localparam logic [ModeW-1:0] MODE_CIRCULATE = 2'd1;
   localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [15:0]       req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [7:0]        rsp_tdata;
   logic              csr_valid;
   logic              csr_ready;
   logic [CsrIdxW-1:0] csr_index;
   logic [SecW-1:0]   csr_data;

   cfg_type           cfg_mirror;
   logic              have_reading;
   logic              last_heat;
   logic [SecW-1:0]   secs_since_flip;
   logic              fan_acked;
   logic              mode_latched;
   logic [ModeW-1:0]  saved_mode;

   rsp_item_type      expected_cmds[$];
   int                fail_count = 0;
   int                cycle_count = 0;
   int                rsp_hold = 0;
   bit                stall_en = 1'b1;

   hvac_fan_overrun_controller_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("hvac_fan_overrun_controller_unit verification failed");
         $finish;
      end
   end

   function automatic rsp_item_type predict_commands(input req_item_type p);
      rsp_item_type    r;
      logic [SecW:0]   total;
      logic            heat_flip;
      logic [SecW-1:0] fan_delay;
      r = '0;
      total = {1'b0, secs_since_flip} + {{(SecW+1-DtW){1'b0}}, p.elapsed_seconds};
      secs_since_flip = (total > {1'b0, SEC_MAX}) ? SEC_MAX : total[SecW-1:0];
      if (p.reading_ok) begin
         heat_flip = have_reading && (p.heat_active != last_heat);
         have_reading = 1'b1;
         last_heat = p.heat_active;
         if (heat_flip) begin
            secs_since_flip = '0;
            fan_acked = 1'b0;
         end else begin
            fan_delay = p.heat_active ? cfg_mirror.fan_on_delay : cfg_mirror.fan_off_delay;
            if (!fan_acked && secs_since_flip > fan_delay) begin
               r.fan_cmd_valid = 1'b1;
               r.fan_speed = p.heat_active ? cfg_mirror.heat_fan_speed
                                           : cfg_mirror.idle_fan_speed;
               fan_acked = p.fan_write_ok;
            end
         end
         if (!p.heat_active && (heat_flip || secs_since_flip < cfg_mirror.blower_overrun)) begin
            if (!mode_latched) begin
               mode_latched = 1'b1;
               saved_mode = p.blower_mode;
            end
            if (p.blower_mode != MODE_ON) begin
               r.blower_cmd_valid = 1'b1;
               r.blower_cmd = MODE_ON;
            end
         end else if (mode_latched) begin
            if (saved_mode == p.blower_mode) begin
               mode_latched = 1'b0;
            end else begin
               r.blower_cmd_valid = 1'b1;
               r.blower_cmd = saved_mode;
            end
         end
      end
      return r;
   endfunction

   function automatic req_item_type make_poll(input logic ok, input logic heat,
                                              input logic [ModeW-1:0] mode,
                                              input logic [DtW-1:0] dt, input logic ack);
      req_item_type p;
      p.reading_ok = ok;
      p.heat_active = heat;
      p.blower_mode = mode;
      p.elapsed_seconds = dt;
      p.fan_write_ok = ack;
      return p;
   endfunction

   task automatic check_field(input string name, input logic [15:0] exp_val,
                              input logic [15:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[6:0];
         if (expected_cmds.size() == 0) begin
            $error("result item with no poll outstanding: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_cmds.pop_front();
            check_field("fan_cmd_valid", 16'(want.fan_cmd_valid), 16'(got.fan_cmd_valid));
            check_field("fan_speed", 16'(want.fan_speed), 16'(got.fan_speed));
            check_field("blower_cmd_valid", 16'(want.blower_cmd_valid),
                        16'(got.blower_cmd_valid));
            check_field("blower_cmd", 16'(want.blower_cmd), 16'(got.blower_cmd));
            check_field("zero fill", 16'd0, 16'(rsp_tdata[7]));
         end
         rsp_hold = stall_en ? $urandom_range(0, 11) : 0;
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // The poll stays offered after acceptance; the next negedge either replaces it
   // or withdraws it, so callers must not let a clock edge pass in between.
   task automatic send_poll(input req_item_type p);
      int gap;
      gap = stall_en ? $urandom_range(0, 11) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {3'b000, p};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_cmds.insert(expected_cmds.size(), predict_commands(p));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [SecW-1:0] value);
      @(negedge clock);
      req_tvalid = 1'b0;
      csr_index = idx;
      csr_data = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FAN_ON_DELAY:   cfg_mirror.fan_on_delay = value;
         CSR_FAN_OFF_DELAY:  cfg_mirror.fan_off_delay = value;
         CSR_BLOWER_OVERRUN: cfg_mirror.blower_overrun = value;
         CSR_HEAT_FAN_SPEED: cfg_mirror.heat_fan_speed = value[SpeedW-1:0];
         CSR_IDLE_FAN_SPEED: cfg_mirror.idle_fan_speed = value[SpeedW-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [SecW-1:0] pick_seconds(input int span);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return '0;
      if (roll < 15) return SEC_MAX;
      return SecW'($urandom_range(0, span));
   endfunction

   task automatic write_all_regs(input logic [SecW-1:0] on_delay,
                                 input logic [SecW-1:0] off_delay,
                                 input logic [SecW-1:0] overrun,
                                 input logic [SpeedW-1:0] heat_speed,
                                 input logic [SpeedW-1:0] idle_speed);
      wait_drained();
      write_reg(CSR_FAN_ON_DELAY, on_delay);
      write_reg(CSR_FAN_OFF_DELAY, off_delay);
      write_reg(CSR_BLOWER_OVERRUN, overrun);
      write_reg(CSR_HEAT_FAN_SPEED, {13'd0, heat_speed});
      write_reg(CSR_IDLE_FAN_SPEED, {13'd0, idle_speed});
   endtask

   task automatic test_reset_defaults();
      send_poll(make_poll(1'b0, 1'b1, MODE_ON, 8'd255, 1'b1));
      send_poll(make_poll(1'b1, 1'b0, MODE_AUTO, 8'd0, 1'b0));
      send_poll(make_poll(1'b1, 1'b0, MODE_AUTO, 8'd15, 1'b1));
      send_poll(make_poll(1'b1, 1'b0, MODE_AUTO, 8'd15, 1'b1));
      wait_drained();
   endtask

   task automatic test_heat_cycle();
      send_poll(make_poll(1'b1, 1'b1, MODE_AUTO, 8'd15, 1'b1));
      send_poll(make_poll(1'b1, 1'b1, MODE_AUTO, 8'd60, 1'b0));
      send_poll(make_poll(1'b1, 1'b1, MODE_AUTO, 8'd1, 1'b0));
      send_poll(make_poll(1'b1, 1'b1, MODE_CIRCULATE, 8'd10, 1'b1));
      send_poll(make_poll(1'b1, 1'b0, MODE_AUTO, 8'd20, 1'b0));
      send_poll(make_poll(1'b1, 1'b0, MODE_ON, 8'd100, 1'b0));
      send_poll(make_poll(1'b0, 1'b0, MODE_CIRCULATE, 8'd255, 1'b0));
      send_poll(make_poll(1'b1, 1'b0, MODE_CIRCULATE, 8'd4, 1'b1));
      send_poll(make_poll(1'b1, 1'b0, MODE_CIRCULATE, 8'd1, 1'b0));
      send_poll(make_poll(1'b1, 1'b0, MODE_AUTO, 8'd1, 1'b0));
      wait_drained();
   endtask

   task automatic test_unused_blower_mode();
      send_poll(make_poll(1'b1, 1'b1, MODE_UNUSED, 8'd0, 1'b1));
      send_poll(make_poll(1'b1, 1'b0, MODE_UNUSED, 8'd0, 1'b1));
      send_poll(make_poll(1'b1, 1'b1, MODE_CIRCULATE, 8'd0, 1'b0));
      send_poll(make_poll(1'b1, 1'b1, MODE_UNUSED, 8'd0, 1'b0));
      wait_drained();
   endtask

   task automatic test_config_extremes();
      write_all_regs('0, '0, '0, 3'd7, 3'd7);
      send_poll(make_poll(1'b1, 1'b1, MODE_AUTO, 8'd0, 1'b0));
      send_poll(make_poll(1'b1, 1'b1, MODE_AUTO, 8'd1, 1'b1));
      send_poll(make_poll(1'b1, 1'b0, MODE_CIRCULATE, 8'd0, 1'b0));
      send_poll(make_poll(1'b1, 1'b0, MODE_ON, 8'd0, 1'b0));
      send_poll(make_poll(1'b1, 1'b0, MODE_CIRCULATE, 8'd255, 1'b1));
      write_all_regs(SEC_MAX, SEC_MAX, SEC_MAX, 3'd0, 3'd0);
      send_poll(make_poll(1'b1, 1'b1, MODE_AUTO, 8'd255, 1'b1));
      send_poll(make_poll(1'b1, 1'b1, MODE_AUTO, 8'd255, 1'b0));
      wait_drained();
   endtask

   task automatic test_random_heat_cycles(input int polls);
      logic             heat_now;
      int               run_left;
      int               roll;
      logic [ModeW-1:0] mode_now;
      logic [DtW-1:0]   dt;
      logic             ok;
      write_all_regs(pick_seconds(400), pick_seconds(400), pick_seconds(600),
                     SpeedW'($urandom_range(0, 7)), SpeedW'($urandom_range(0, 7)));
      stall_en = ($urandom_range(0, 3) != 0);
      heat_now = logic'($urandom_range(0, 1));
      run_left = $urandom_range(1, 30);
      mode_now = ModeW'($urandom_range(0, 2));
      for (int i = 0; i < polls; i++) begin
         if (run_left == 0) begin
            heat_now = !heat_now;
            run_left = $urandom_range(1, 30);
         end
         run_left--;
         if ($urandom_range(0, 3) == 0)
            mode_now = ($urandom_range(0, 9) == 0) ? MODE_UNUSED
                                                   : ModeW'($urandom_range(0, 2));
         roll = $urandom_range(0, 9);
         if (roll < 7) dt = DtW'($urandom_range(0, 60));
         else if (roll < 9) dt = DtW'($urandom_range(0, 255));
         else dt = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         ok = ($urandom_range(0, 9) != 0);
         send_poll(make_poll(ok, ok ? heat_now : logic'($urandom_range(0, 1)), mode_now, dt,
                             logic'($urandom_range(0, 1))));
         if ($urandom_range(0, 24) == 0)
            stall_en = !stall_en;
         if ($urandom_range(0, 39) == 0)
            wait_drained();
      end
      wait_drained();
   endtask

   task automatic test_counter_saturation(input int polls);
      logic [ModeW-1:0] mode_now;
      write_all_regs(pick_seconds(400), SEC_MAX - SecW'($urandom_range(0, 1)), SEC_MAX,
                     SpeedW'($urandom_range(0, 7)), SpeedW'($urandom_range(0, 7)));
      stall_en = 1'b0;
      mode_now = MODE_AUTO;
      send_poll(make_poll(1'b1, 1'b1, mode_now, 8'd0, 1'b0));
      for (int i = 0; i < polls; i++) begin
         if ($urandom_range(0, 19) == 0)
            mode_now = ModeW'($urandom_range(0, 3));
         send_poll(make_poll($urandom_range(0, 19) != 0, 1'b0, mode_now,
                             ($urandom_range(0, 9) != 0) ? 8'd255
                                                         : DtW'($urandom_range(0, 255)),
                             $urandom_range(0, 3) == 0));
         if (i == polls / 2)
            stall_en = 1'b1;
      end
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_FAN_ON_DELAY;
      csr_data = '0;
      cfg_mirror.fan_on_delay = RST_FAN_ON_DELAY;
      cfg_mirror.fan_off_delay = RST_FAN_OFF_DELAY;
      cfg_mirror.blower_overrun = RST_BLOWER_OVERRUN;
      cfg_mirror.heat_fan_speed = RST_HEAT_FAN_SPEED;
      cfg_mirror.idle_fan_speed = RST_IDLE_FAN_SPEED;
      have_reading = 1'b0;
      last_heat = 1'b0;
      secs_since_flip = RST_SINCE_CHANGE;
      fan_acked = 1'b0;
      mode_latched = 1'b0;
      saved_mode = MODE_AUTO;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_heat_cycle();
      test_unused_blower_mode();
      test_config_extremes();
      for (int phase = 0; phase < 4; phase++)
         test_random_heat_cycles(80);
      test_counter_saturation(265);
      for (int phase = 0; phase < 3; phase++)
         test_random_heat_cycles(80);

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("hvac_fan_overrun_controller_unit verification clean");
      end else begin
         $display("hvac_fan_overrun_controller_unit verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/hfoc_pkg.sv
hw/rtl/hfoc_csr.sv
hw/rtl/hfoc_core.sv
hw/rtl/hvac_fan_overrun_controller_unit.sv
sim/hvac_fan_overrun_controller_unit_tb.sv
